// ===== hw/rtl/multichannel_pid_controller_macros.svh =====
// Assertion macros for the multichannel PID controller checker.
// MPID_ASSERT expects signals named clock and reset in the using scope, MPID_ASSERT_RST only clock.
`ifndef MULTICHANNEL_PID_CONTROLLER_MACROS_SVH
`define MULTICHANNEL_PID_CONTROLLER_MACROS_SVH

// Concurrent assertion, switched off while reset is high
`define MPID_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Concurrent assertion that also holds through reset
`define MPID_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== hw/rtl/mpid_pkg.sv =====
// Shared types, widths and register codes for the multichannel PID controller.
// No dependencies; used by the top level, its checker and the bench.
`default_nettype none

package mpid_pkg;

   // field and datapath widths
   localparam int AxisW    = 3;
   localparam int ValW     = 17;
   localparam int ErrW     = 18;
   localparam int DiffW    = 19;
   localparam int SumW     = 32;
   localparam int GainW    = 32;
   localparam int LimW     = 16;
   localparam int DriveW   = 48;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;

   // clamp arithmetic runs two bits wider than the stored sum
   localparam int SumXW    = SumW + 2;
   // products: signed gain (one extra bit) times operand
   localparam int PropW    = GainW + 1 + ErrW;
   localparam int IntW     = GainW + 1 + SumW;
   localparam int DerW     = GainW + 1 + DiffW;
   // accumulator holds the sum of the three products without overflow
   localparam int AccW     = IntW + 1;

   localparam logic signed [SumXW-1:0] SumMax = {3'b000, {(SumW-1){1'b1}}};
   localparam logic signed [SumXW-1:0] SumMin = {3'b111, {(SumW-1){1'b0}}};
   localparam logic signed [AccW-1:0]  DriveMax =
      {{(AccW-DriveW+1){1'b0}}, {(DriveW-1){1'b1}}};
   localparam logic signed [AccW-1:0]  DriveMin =
      {{(AccW-DriveW+1){1'b1}}, {(DriveW-1){1'b0}}};

   // loop kind code
   localparam logic FuncSpeed = 1'b1;

   // configuration register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_POS_KP,
      CSR_POS_KI,
      CSR_POS_KD,
      CSR_SPD_KP,
      CSR_SPD_KI,
      CSR_SPD_KD,
      CSR_SUM_LIMIT
   } csr_index_type;

   // configuration reset values
   localparam logic [GainW-1:0] PosKpReset  = 32'd655360;
   localparam logic [GainW-1:0] PosKiReset  = 32'd2621;
   localparam logic [GainW-1:0] PosKdReset  = 32'd26214;
   localparam logic [GainW-1:0] SpdKpReset  = 32'd26214400;
   localparam logic [GainW-1:0] SpdKiReset  = 32'd0;
   localparam logic [GainW-1:0] SpdKdReset  = 32'd983040;
   localparam logic [LimW-1:0]  SumLimReset = 16'd3000;

   // one state memory entry: error sum and previous error
   typedef struct packed {
      logic signed [SumW-1:0] sum;
      logic signed [ErrW-1:0] last;
   } slot_type;

endpackage

`default_nettype wire

// ===== hw/rtl/multichannel_pid_controller.sv =====
// Multichannel PID controller: each input transfer passes the stage 1, stage 2 and
// stage 3 registers and the result register before its result is offered on rsp_valid.
// Throughput one item per cycle while no stall holds the result; the state memory read plus
// write-back forwarding into stage 1 and the three gain multipliers ahead of stage 3 set that figure.
// Reset (synchronous) clears the pipeline, loads default gains and clears the
// per-entry valid bits, so every loop state reads as zero; no clearing pass.
`default_nettype none

module multichannel_pid_controller #(
   parameter int AXES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mpid_pkg::AxisW-1:0]           req_axis,
   input  logic                                 req_func,
   input  logic signed [mpid_pkg::ValW-1:0]     req_measured,
   input  logic signed [mpid_pkg::ValW-1:0]     req_target,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mpid_pkg::DriveW-1:0]   rsp_drive,
   output logic                                 rsp_sum_clamped,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mpid_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [mpid_pkg::CsrDataW-1:0]        csr_data
);
   import mpid_pkg::*;

   localparam int SLOTS = 2 * AXES;
   localparam int IDX_W = $clog2(SLOTS);

   // ---------------------------------------------------------------
   // configuration registers
   logic [GainW-1:0] pos_kp_ff, pos_ki_ff, pos_kd_ff;
   logic [GainW-1:0] spd_kp_ff, spd_ki_ff, spd_kd_ff;
   logic [LimW-1:0]  sum_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_kp_ff    <= PosKpReset;
         pos_ki_ff    <= PosKiReset;
         pos_kd_ff    <= PosKdReset;
         spd_kp_ff    <= SpdKpReset;
         spd_ki_ff    <= SpdKiReset;
         spd_kd_ff    <= SpdKdReset;
         sum_limit_ff <= SumLimReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_POS_KP:    pos_kp_ff    <= csr_data;
            CSR_POS_KI:    pos_ki_ff    <= csr_data;
            CSR_POS_KD:    pos_kd_ff    <= csr_data;
            CSR_SPD_KP:    spd_kp_ff    <= csr_data;
            CSR_SPD_KI:    spd_ki_ff    <= csr_data;
            CSR_SPD_KD:    spd_kd_ff    <= csr_data;
            CSR_SUM_LIMIT: sum_limit_ff <= csr_data[LimW-1:0];
            default: ;     // unknown index: ignored
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pipeline flow control: each stage moves when the next is free
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, rsp_valid_ff;
   logic out_free, s3_free, s2_free, s1_free;
   logic req_fire, s1_fire;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s3_free   = !s3_vld_ff || out_free;
   assign s2_free   = !s2_vld_ff || s3_free;
   assign s1_free   = !s1_vld_ff || s2_free;
   assign req_fire  = req_valid && s1_free;
   assign s1_fire   = s1_vld_ff && s2_free;
   assign req_stall = !s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire)
            s1_vld_ff <= 1'b1;
         else if (s1_fire)
            s1_vld_ff <= 1'b0;
         if (s2_free)
            s2_vld_ff <= s1_vld_ff;
         if (s3_free)
            s3_vld_ff <= s2_vld_ff;
         if (out_free)
            rsp_valid_ff <= s3_vld_ff;
      end
   end

   // ---------------------------------------------------------------
   // entry index and range check of the incoming transfer
   logic [IDX_W+AxisW:0] req_idx_wide;
   logic [IDX_W-1:0]     req_idx;
   logic                 req_ok;

   assign req_idx_wide = {{IDX_W{1'b0}}, req_axis, req_func};
   assign req_idx      = req_idx_wide[IDX_W-1:0];
   assign req_ok       = int'(req_axis) < AXES;

   // stage 1 input registers
   logic                   s1_ok_ff, s1_func_ff;
   logic [IDX_W-1:0]       s1_idx_ff;
   logic signed [ValW-1:0] s1_meas_ff, s1_targ_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ok_ff   <= req_ok;
         s1_func_ff <= req_func;
         s1_idx_ff  <= req_idx;
         s1_meas_ff <= req_measured;
         s1_targ_ff <= req_target;
      end
   end

   // ---------------------------------------------------------------
   // state memory, read on transfer, written back when stage 1 moves on
   slot_type         mem [SLOTS];
   slot_type         rd_ff;
   slot_type         fwd_ff;
   logic             fwd_sel_ff;
   logic             rd_vld_ff;
   logic [SLOTS-1:0] vld_ff;
   logic             wr_en;
   slot_type         wr_data;
   logic             fwd_in;

   assign wr_en  = s1_fire && s1_ok_ff;
   // same entry written at this edge: take the new value instead
   assign fwd_in = wr_en && (s1_idx_ff == req_idx);

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[s1_idx_ff] <= wr_data;
      if (req_fire)
         rd_ff <= mem[req_idx];
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_vld_ff  <= vld_ff[req_idx];
         fwd_sel_ff <= fwd_in;
         fwd_ff     <= wr_data;
      end
   end

   // valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (wr_en)
         vld_ff[s1_idx_ff] <= 1'b1;
   end

   // ---------------------------------------------------------------
   // stage 1: error, clamped sum, difference to previous error
   slot_type                cur;
   logic signed [ErrW-1:0]  err_in;
   logic signed [SumXW-1:0] sum_raw, lim_hi, lim_lo, sum_sel;
   logic signed [DiffW-1:0] diff_in;
   logic                    clamp_in;
   logic signed [ValW:0]    meas_x, targ_x;

   always_comb begin
      if (fwd_sel_ff)
         cur = fwd_ff;
      else if (rd_vld_ff)
         cur = rd_ff;
      else
         cur = '0;

      meas_x = {s1_meas_ff[ValW-1], s1_meas_ff};
      targ_x = {s1_targ_ff[ValW-1], s1_targ_ff};
      if (s1_func_ff == FuncSpeed)
         err_in = targ_x - meas_x;
      else
         err_in = meas_x - targ_x;

      sum_raw = {{(SumXW-SumW){cur.sum[SumW-1]}}, cur.sum}
              + {{(SumXW-ErrW){err_in[ErrW-1]}}, err_in};

      // speed loop saturates at 32 bits, position loop clamps to the limit
      if (s1_func_ff == FuncSpeed) begin
         lim_hi = SumMax;
         lim_lo = SumMin;
      end else begin
         lim_hi = {{(SumXW-LimW){1'b0}}, sum_limit_ff};
         lim_lo = -lim_hi;
      end

      clamp_in = 1'b1;
      if (sum_raw > lim_hi)
         sum_sel = lim_hi;
      else if (sum_raw < lim_lo)
         sum_sel = lim_lo;
      else begin
         sum_sel  = sum_raw;
         clamp_in = 1'b0;
      end

      diff_in = {err_in[ErrW-1], err_in} - {cur.last[ErrW-1], cur.last};

      wr_data.sum  = sum_sel[SumW-1:0];
      wr_data.last = err_in;
   end

   // stage 2 registers
   logic                    s2_ok_ff, s2_func_ff, s2_clamp_ff;
   logic signed [ErrW-1:0]  s2_err_ff;
   logic signed [SumW-1:0]  s2_sum_ff;
   logic signed [DiffW-1:0] s2_diff_ff;

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_ok_ff    <= s1_ok_ff;
         s2_func_ff  <= s1_func_ff;
         s2_clamp_ff <= clamp_in;
         s2_err_ff   <= err_in;
         s2_sum_ff   <= sum_sel[SumW-1:0];
         s2_diff_ff  <= diff_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2 to 3: the three gain products
   logic [GainW-1:0]        kp, ki, kd;
   logic signed [PropW-1:0] p_prop_in, p_prop_ff;
   logic signed [IntW-1:0]  p_int_in, p_int_ff;
   logic signed [DerW-1:0]  p_der_in, p_der_ff;
   logic                    s3_ok_ff, s3_clamp_ff;

   always_comb begin
      if (s2_func_ff == FuncSpeed) begin
         kp = spd_kp_ff;
         ki = spd_ki_ff;
         kd = spd_kd_ff;
      end else begin
         kp = pos_kp_ff;
         ki = pos_ki_ff;
         kd = pos_kd_ff;
      end
      p_prop_in = $signed({1'b0, kp}) * s2_err_ff;
      p_int_in  = $signed({1'b0, ki}) * s2_sum_ff;
      p_der_in  = $signed({1'b0, kd}) * s2_diff_ff;
   end

   always_ff @(posedge clock) begin
      if (s3_free) begin
         p_prop_ff   <= p_prop_in;
         p_int_ff    <= p_int_in;
         p_der_ff    <= p_der_in;
         s3_ok_ff    <= s2_ok_ff;
         s3_clamp_ff <= s2_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3 to output: sum of terms, saturate to 48 bits
   logic signed [AccW-1:0]   acc;
   logic signed [DriveW-1:0] drive_in, rsp_drive_ff;
   logic                     rsp_clamp_ff;

   always_comb begin
      acc = {{(AccW-PropW){p_prop_ff[PropW-1]}}, p_prop_ff}
          + {{(AccW-IntW){p_int_ff[IntW-1]}}, p_int_ff}
          + {{(AccW-DerW){p_der_ff[DerW-1]}}, p_der_ff};
      if (!s3_ok_ff)
         drive_in = '0;
      else if (acc > DriveMax)
         drive_in = DriveMax[DriveW-1:0];
      else if (acc < DriveMin)
         drive_in = DriveMin[DriveW-1:0];
      else
         drive_in = acc[DriveW-1:0];
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_drive_ff <= drive_in;
         rsp_clamp_ff <= s3_ok_ff && s3_clamp_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive       = rsp_drive_ff;
   assign rsp_sum_clamped = rsp_clamp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mpid_checker.sv =====
// Port-level checker for the multichannel PID controller, with its bind.
// Depends on mpid_pkg and multichannel_pid_controller_macros.svh.
`default_nettype none
`include "multichannel_pid_controller_macros.svh"

module mpid_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [mpid_pkg::DriveW-1:0]   rsp_drive,
   input  logic                                 rsp_sum_clamped
);

   // pipeline empties and input opens straight after reset
   `MPID_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid && !req_stall, "not idle after reset")

   // an accepted transfer is checked to be followed by an offered result
   `MPID_ASSERT(a_latency, req_valid && !req_stall |-> ##4 rsp_valid, "result late")

   // a stalled result stays offered
   `MPID_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "result dropped")

   // and its payload holds
   `MPID_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_drive) && $stable(rsp_sum_clamped), "payload moved")

endmodule

bind multichannel_pid_controller mpid_checker u_mpid_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_drive       (rsp_drive),
   .rsp_sum_clamped (rsp_sum_clamped)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the multichannel PID controller: a clocked driver, a
// monitor and an in-order predictor of drive value and clamp flag per axis.
// Depends on mpid_pkg and the multichannel_pid_controller top level.
`timescale 1ns / 1ps

module testbench;
   import mpid_pkg::*;

   localparam int Axes = 8;
   localparam int CycleLimit = 2_000_000;
   localparam logic FuncPosition = ~FuncSpeed;
   localparam logic [CsrIdxW-1:0] CsrUnused = 3'd7;
   localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
   localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
   localparam logic [63:0] TermCap = 64'd1 << 60;
   localparam longint DriveHi = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint DriveLo = -DriveHi - 1;
   localparam longint SumHi = 64'sd2147483647;
   localparam longint SumLo = -SumHi - 1;

   typedef struct packed {
      logic [AxisW-1:0]       axis;
      logic                   func;
      logic signed [ValW-1:0] measured;
      logic signed [ValW-1:0] target;
   } pid_sample_type;

   typedef struct packed {
      logic signed [DriveW-1:0] drive;
      logic                     sum_clamped;
   } pid_result_type;

   // DUT connections, all inputs known from time zero
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [AxisW-1:0]         req_axis = '0;
   logic                     req_func = 1'b0;
   logic signed [ValW-1:0]   req_measured = '0;
   logic signed [ValW-1:0]   req_target = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DriveW-1:0] rsp_drive;
   logic                     rsp_sum_clamped;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIdxW-1:0]       csr_index = '0;
   logic [CsrDataW-1:0]      csr_data = '0;

   // predictor copy of registers and loop state
   logic [GainW-1:0] gain_model [6];
   logic [LimW-1:0]  limit_model;
   int               sum_model [2*Axes];
   int               last_model [2*Axes];

   pid_sample_type sample_queue [$];
   pid_result_type drive_expected [$];
   pid_sample_type next_sample;
   pid_result_type want;
   int          issued = 0;
   int          results_seen = 0;
   int          errors = 0;
   int          cycles = 0;
   int          req_gap = 0;
   int          rsp_hold = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;

   multichannel_pid_controller #(.AXES(Axes)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_axis        (req_axis),
      .req_func        (req_func),
      .req_measured    (req_measured),
      .req_target      (req_target),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive       (rsp_drive),
      .rsp_sum_clamped (rsp_sum_clamped),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // gain times signed operand, magnitude held to 2^60
   function automatic longint gain_term(logic [GainW-1:0] gain, longint x);
      logic [63:0] mag;
      logic [63:0] prod;
      mag = (x < 0) ? 64'(-x) : 64'(x);
      prod = {32'd0, gain} * mag;
      if (prod > TermCap) prod = TermCap;
      return (x < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   // one PID step on the predictor state
   function automatic pid_result_type pid_drive_of(logic [AxisW-1:0] axis, logic func,
                                                   logic signed [ValW-1:0] meas,
                                                   logic signed [ValW-1:0] targ);
      int          slot;
      longint      e, s, d, acc, lim;
      logic [GainW-1:0] kp, ki, kd;
      pid_result_type r;
      r = '0;
      if (int'(axis) >= Axes) return r;
      slot = int'(axis) * 2 + int'(func);
      if (func == FuncSpeed) begin
         e = longint'(targ) - longint'(meas);
         s = longint'(sum_model[slot]) + e;
         if (s > SumHi) begin s = SumHi; r.sum_clamped = 1'b1; end
         if (s < SumLo) begin s = SumLo; r.sum_clamped = 1'b1; end
         kp = gain_model[CSR_SPD_KP];
         ki = gain_model[CSR_SPD_KI];
         kd = gain_model[CSR_SPD_KD];
      end else begin
         lim = longint'(limit_model);
         e = longint'(meas) - longint'(targ);
         s = longint'(sum_model[slot]) + e;
         if (s > lim) begin s = lim; r.sum_clamped = 1'b1; end
         if (s < -lim) begin s = -lim; r.sum_clamped = 1'b1; end
         kp = gain_model[CSR_POS_KP];
         ki = gain_model[CSR_POS_KI];
         kd = gain_model[CSR_POS_KD];
      end
      d = e - longint'(last_model[slot]);
      acc = gain_term(kp, e) + gain_term(ki, s) + gain_term(kd, d);
      if (acc > DriveHi) acc = DriveHi;
      if (acc < DriveLo) acc = DriveLo;
      sum_model[slot] = int'(s);
      last_model[slot] = int'(e);
      r.drive = acc[DriveW-1:0];
      return r;
   endfunction

   function automatic logic signed [ValW-1:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return ValMax;
         1: return ValMin;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // mix of full-range, near-setpoint and corner samples
   function automatic pid_sample_type random_sample();
      pid_sample_type smp;
      smp.axis = AxisW'($urandom_range(0, Axes - 1));
      smp.func = 1'($urandom_range(0, 1));
      smp.target = ValW'($urandom);
      case ($urandom_range(0, 4))
         0, 1: smp.measured = ValW'($urandom);
         2, 3: smp.measured = smp.target + ValW'($urandom_range(0, 128)) - ValW'(64);
         default: begin
            smp.measured = pick_extreme();
            smp.target = pick_extreme();
         end
      endcase
      return smp;
   endfunction

   task automatic add_sample(logic [AxisW-1:0] ax, logic fn,
                             logic signed [ValW-1:0] m, logic signed [ValW-1:0] t);
      pid_sample_type smp;
      smp.axis = ax;
      smp.func = fn;
      smp.measured = m;
      smp.target = t;
      sample_queue.push_back(smp);
      issued++;
   endtask

   task automatic add_random(int count);
      for (int i = 0; i < count; i++) begin
         sample_queue.push_back(random_sample());
         issued++;
      end
   endtask

   // register write over the CSR channel, mirrored into the predictor
   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx) inside
         CSR_POS_KP, CSR_POS_KI, CSR_POS_KD,
         CSR_SPD_KP, CSR_SPD_KI, CSR_SPD_KD: gain_model[idx] = val;
         CSR_SUM_LIMIT: limit_model = val[LimW-1:0];
         default: ;
      endcase
   endtask

   // block is idle once every issued sample has produced its result
   task automatic finish_phase();
      while (results_seen != issued) @(negedge clock);
   endtask

   // request driver: one transfer per accepted sample, random gaps between
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            drive_expected.push_back(pid_drive_of(req_axis, req_func,
                                                  req_measured, req_target));
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               next_sample = sample_queue.pop_front();
               req_axis <= next_sample.axis;
               req_func <= next_sample.func;
               req_measured <= next_sample.measured;
               req_target <= next_sample.target;
               req_valid <= 1'b1;
               if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
               req_gap = req_calm ? 0 : $urandom_range(0, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (drive_expected.size() == 0) begin
               if (errors < 10)
                  $display("unexpected result: drive %0d clamp %0b",
                           rsp_drive, rsp_sum_clamped);
               errors++;
            end else begin
               want = drive_expected.pop_front();
               if (rsp_drive !== want.drive || rsp_sum_clamped !== want.sum_clamped) begin
                  if (errors < 10)
                     $display("mismatch on result %0d: drive exp %0d got %0d, clamp exp %0b got %0b",
                              results_seen, want.drive, rsp_drive,
                              want.sum_clamped, rsp_sum_clamped);
                  errors++;
               end
            end
            results_seen++;
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 4);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      gain_model[CSR_POS_KP] = PosKpReset;
      gain_model[CSR_POS_KI] = PosKiReset;
      gain_model[CSR_POS_KD] = PosKdReset;
      gain_model[CSR_SPD_KP] = SpdKpReset;
      gain_model[CSR_SPD_KI] = SpdKiReset;
      gain_model[CSR_SPD_KD] = SpdKdReset;
      limit_model = SumLimReset;
      for (int i = 0; i < 2*Axes; i++) begin
         sum_model[i] = 0;
         last_model[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset gains: field extremes, both loops, every axis
      add_sample(AxisW'(0), FuncPosition, ValMax, ValMin);
      add_sample(AxisW'(0), FuncPosition, ValMin, ValMax);
      add_sample(AxisW'(1), FuncSpeed, ValMin, ValMax);
      add_sample(AxisW'(1), FuncSpeed, ValMax, ValMin);
      add_sample(AxisW'(2), FuncPosition, ValMax, ValMax);
      add_sample(AxisW'(2), FuncSpeed, ValMin, ValMin);
      for (int a = 0; a < Axes; a++)
         add_sample(AxisW'(a), 1'(a), ValW'(a * 100 - 300), ValW'(5));
      add_random(90);
      finish_phase();

      // every gain and the limit at their maximum: drive saturates
      for (int i = CSR_POS_KP; i <= CSR_SPD_KD; i++)
         write_reg(CsrIdxW'(i), '1);
      write_reg(CSR_SUM_LIMIT, 32'h0000_FFFF);
      add_random(70);
      finish_phase();

      // everything zero: zero drive, limit of zero clamps any nonzero sum
      for (int i = CSR_POS_KP; i <= CSR_SPD_KD; i++)
         write_reg(CsrIdxW'(i), '0);
      write_reg(CSR_SUM_LIMIT, '0);
      add_random(50);
      finish_phase();

      // random gains over a range of magnitudes, upper data bits set too
      for (int i = CSR_POS_KP; i <= CSR_SPD_KD; i++)
         write_reg(CsrIdxW'(i), $urandom >> $urandom_range(0, 31));
      write_reg(CSR_SUM_LIMIT, $urandom);
      add_random(90);
      finish_phase();

      // build position sums under a wide limit, then lower it below them
      write_reg(CSR_SUM_LIMIT, 32'd60000);
      for (int a = 0; a < Axes; a++) begin
         add_sample(AxisW'(a), FuncPosition, (a % 2) ? -ValW'(20000) : ValW'(20000), '0);
         add_sample(AxisW'(a), FuncPosition, (a % 2) ? -ValW'(20000) : ValW'(20000), '0);
      end
      finish_phase();
      write_reg(CSR_SUM_LIMIT, 32'd5);
      for (int a = 0; a < Axes; a++)
         add_sample(AxisW'(a), FuncPosition, ValW'(a * 7), ValW'(a * 7));
      finish_phase();

      // write to an unused index must leave every register alone
      write_reg(CsrUnused, $urandom);
      write_reg(CSR_SUM_LIMIT, $urandom_range(100, 20000));
      add_random(90);
      finish_phase();

      // speed sums pushed hard both ways under a full integral gain
      write_reg(CSR_SPD_KI, '1);
      write_reg(CSR_SPD_KP, $urandom >> 8);
      write_reg(CSR_SPD_KD, $urandom >> 8);
      for (int n = 0; n < 15; n++) begin
         add_sample(AxisW'(3), FuncSpeed, ValMin, ValMax);
         add_sample(AxisW'(6), FuncSpeed, ValMax, ValMin);
      end
      add_random(30);
      finish_phase();

      // closing mix with moderate gains
      for (int i = CSR_POS_KP; i <= CSR_SPD_KD; i++)
         write_reg(CsrIdxW'(i), $urandom_range(0, 32'h0010_0000));
      write_reg(CSR_SUM_LIMIT, $urandom_range(0, 65535));
      add_random(60);
      finish_phase();

      // let any stray result surface before judging
      repeat (20) @(posedge clock);
      if (drive_expected.size() != 0) errors++;
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mpid_pkg.sv
hw/rtl/multichannel_pid_controller.sv
hw/rtl/mpid_checker.sv
bench/testbench.sv
